// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, included by the top-level parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, suspended while in reset.
`define HHFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition seen at one edge leads to a consequence at the next.
`define HHFP_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: rtl/core/hhfp_pkg.sv
// ----------------------------------------------------------------------------
// hhfp_pkg
// Types, codes and character classes for the header field parser.
// ----------------------------------------------------------------------------
package hhfp_pkg;

    localparam int unsigned MAX_FIELD_LEN_DEF = 4095;
    localparam int unsigned OUT_W             = 12;

    typedef enum logic [2:0] {
        ST_NAME   = 3'd0,
        ST_VSTART = 3'd1,
        ST_VALUE  = 3'd2,
        ST_CR     = 3'd3,
        ST_DONE   = 3'd4,
        ST_ERROR  = 3'd5
    } parse_state_t;

    typedef enum logic [1:0] {
        STAT_PROGRESS = 2'd0,
        STAT_OK       = 2'd1,
        STAT_FAIL     = 2'd2,
        STAT_IGNORED  = 2'd3
    } status_t;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        status_t            status;
        logic [OUT_W-1:0]   name_length;
        logic [OUT_W-1:0]   value_offset;
        logic [OUT_W-1:0]   value_length;
        logic [OUT_W-1:0]   byte_position;
    } result_t;

    function automatic logic is_token_char(logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A))
        begin
            hit = 1'b1;
        end
        else
        begin
            case (c)
                8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
                8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C,
                8'h7E:   hit = 1'b1;
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    function automatic logic is_value_char(logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h7E) || c[7];
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    // Keep the low bits of a zero-extended count for an output field.
    function automatic logic [OUT_W-1:0] to_out(logic [31:0] v);
        return v[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/core/hhfp_byte_if.sv
// ----------------------------------------------------------------------------
// hhfp_byte_if
// Input channel: one header byte per beat plus a restart flag.
// ----------------------------------------------------------------------------
interface hhfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       clear;

    modport source (output valid, output byte_value, output clear, input ready);
    modport sink   (input valid, input byte_value, input clear, output ready);
endinterface

// File: rtl/core/hhfp_result_if.sv
// ----------------------------------------------------------------------------
// hhfp_result_if
// Output channel: one parse result per beat.
// ----------------------------------------------------------------------------
interface hhfp_result_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [hhfp_pkg::OUT_W-1:0] name_length;
    logic [hhfp_pkg::OUT_W-1:0] value_offset;
    logic [hhfp_pkg::OUT_W-1:0] value_length;
    logic [hhfp_pkg::OUT_W-1:0] byte_position;

    modport source (output valid, output status, output name_length, output value_offset,
                    output value_length, output byte_position, input ready);
    modport sink   (input valid, input status, input name_length, input value_offset,
                    input value_length, input byte_position, output ready);
endinterface

// File: rtl/core/hhfp_step.sv
// ----------------------------------------------------------------------------
// hhfp_step
// Next-state and result logic for one header byte.
// ----------------------------------------------------------------------------
module hhfp_step #(
    parameter int unsigned MAX_FIELD_LEN = hhfp_pkg::MAX_FIELD_LEN_DEF,
    parameter int unsigned PW            = $clog2(MAX_FIELD_LEN + 1)
) (
    input  logic [7:0]             byte_value,
    input  logic                   clear,
    input  hhfp_pkg::parse_state_t state_cur,
    input  logic [PW-1:0]          pos_cur,
    input  logic [PW-1:0]          name_cur,
    input  logic [PW-1:0]          vbegin_cur,
    input  logic [PW-1:0]          vend_cur,
    output hhfp_pkg::parse_state_t state_nxt,
    output logic [PW-1:0]          pos_nxt,
    output logic [PW-1:0]          name_nxt,
    output logic [PW-1:0]          vbegin_nxt,
    output logic [PW-1:0]          vend_nxt,
    output hhfp_pkg::result_t      result
);
    import hhfp_pkg::*;

    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FIELD_LEN);

    parse_state_t  st;
    logic [PW-1:0] pos;
    logic [PW-1:0] nxt;
    logic [PW-1:0] vlen;
    logic          fail;
    status_t       status;

    always_comb
    begin
        // Restart ahead of this byte when clear is set.
        st         = clear ? ST_NAME : state_cur;
        pos        = clear ? '0 : pos_cur;
        name_nxt   = clear ? '0 : name_cur;
        vbegin_nxt = clear ? '0 : vbegin_cur;
        vend_nxt   = clear ? '0 : vend_cur;
        state_nxt  = st;
        pos_nxt    = pos;
        nxt        = pos + PW'(1);
        fail       = 1'b0;
        status     = STAT_PROGRESS;

        priority if (st != ST_NAME && st != ST_VSTART && st != ST_VALUE && st != ST_CR)
        begin
            status = STAT_IGNORED;
        end
        else if (pos >= POS_MAX)
        begin
            state_nxt = ST_ERROR;
            status    = STAT_FAIL;
        end
        else
        begin
            pos_nxt = nxt;
            unique case (st)
                ST_NAME:
                begin
                    if (is_token_char(byte_value))
                        name_nxt = nxt;
                    else if (byte_value == CH_COLON && name_nxt != '0)
                        state_nxt = ST_VSTART;
                    else
                        fail = 1'b1;
                end
                ST_VSTART:
                begin
                    if (is_blank(byte_value))
                    begin
                        state_nxt = ST_VSTART;
                    end
                    else if (is_value_char(byte_value))
                    begin
                        vend_nxt   = nxt;
                        vbegin_nxt = pos;
                        state_nxt  = ST_VALUE;
                    end
                    else if (byte_value == CH_CR)
                        state_nxt = ST_CR;
                    else
                        fail = 1'b1;
                end
                ST_VALUE:
                begin
                    if (is_value_char(byte_value))
                        vend_nxt = nxt;
                    else if (is_blank(byte_value))
                        state_nxt = ST_VALUE;
                    else if (byte_value == CH_CR)
                        state_nxt = ST_CR;
                    else
                        fail = 1'b1;
                end
                default:
                begin
                    if (byte_value == CH_LF)
                    begin
                        state_nxt = ST_DONE;
                        status    = STAT_OK;
                    end
                    else
                        fail = 1'b1;
                end
            endcase
            if (fail)
            begin
                state_nxt = ST_ERROR;
                status    = STAT_FAIL;
            end
        end

        vlen = (vbegin_nxt != '0 && vend_nxt >= vbegin_nxt) ? vend_nxt - vbegin_nxt : '0;

        result.status        = status;
        result.name_length   = to_out(32'(name_nxt));
        result.value_offset  = to_out(32'(vbegin_nxt));
        result.value_length  = to_out(32'(vlen));
        result.byte_position = to_out(32'(pos));
    end

endmodule

// File: rtl/core/http_header_field_parser.sv
// ----------------------------------------------------------------------------
// http_header_field_parser
// Byte-serial checker for one HTTP header field line: name ':' OWS value OWS
// CR LF. Every byte beat yields one result beat carrying status (in progress,
// done on LF, error, ignored), name length, value offset, value length with
// trailing blanks dropped, and the byte's position in the line. The block
// takes one byte per cycle unless the output stalls: the parse state and
// counters update at the input handshake and the result lands in an output
// register in the same edge. Input ready follows the output register and the
// output ready, so a byte is taken whenever the result register is empty or
// being drained in that cycle. After done or error, bytes report "ignored"
// until a beat with clear set restarts the parse ahead of its own byte. The
// position counter stops at MAX_FIELD_LEN; a byte that arrives at that bound
// is an error. There is no reset sweep and no configuration.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module http_header_field_parser #(
    parameter int unsigned MAX_FIELD_LEN = hhfp_pkg::MAX_FIELD_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    hhfp_byte_if.sink     byte_in,
    hhfp_result_if.source result_out
);
    import hhfp_pkg::*;

    localparam int unsigned   PW      = $clog2(MAX_FIELD_LEN + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FIELD_LEN);

    // Parse state and counters, updated only on an accepted byte beat.
    parse_state_t  state_reg,  state_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic [PW-1:0] name_reg,   name_next;
    logic [PW-1:0] vbegin_reg, vbegin_next;
    logic [PW-1:0] vend_reg,   vend_next;

    // Output register: valid is control, the payload needs no reset.
    logic          out_valid_reg;
    result_t       res_reg;
    result_t       res_next;

    logic          accept;

    // Take a byte whenever the result register is empty or frees up this cycle.
    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    hhfp_step #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .PW            (PW)
    ) u_step (
        .byte_value (byte_in.byte_value),
        .clear      (byte_in.clear),
        .state_cur  (state_reg),
        .pos_cur    (pos_reg),
        .name_cur   (name_reg),
        .vbegin_cur (vbegin_reg),
        .vend_cur   (vend_reg),
        .state_nxt  (state_next),
        .pos_nxt    (pos_next),
        .name_nxt   (name_next),
        .vbegin_nxt (vbegin_next),
        .vend_nxt   (vend_next),
        .result     (res_next)
    );

    // Advance the parse on every accepted beat; hold otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_NAME;
            pos_reg    <= '0;
            name_reg   <= '0;
            vbegin_reg <= '0;
            vend_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            name_reg   <= name_next;
            vbegin_reg <= vbegin_next;
            vend_reg   <= vend_next;
        end
    end

    // Output valid: set by an accepted beat, dropped once the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload alongside the state update.
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.status        = res_reg.status;
    assign result_out.name_length   = res_reg.name_length;
    assign result_out.value_offset  = res_reg.value_offset;
    assign result_out.value_length  = res_reg.value_length;
    assign result_out.byte_position = res_reg.byte_position;

    // The position counter saturates at the bound.
    `HHFP_ASSERT(a_pos_bound, pos_reg <= POS_MAX, "position counter passed its bound")

    // Every accepted byte leaves a result waiting.
    `HHFP_ASSERT_NEXT(a_accept_result, accept, out_valid_reg,
        "accepted byte produced no result")

    // A byte in done or error without clear changes no counter.
    `HHFP_ASSERT_NEXT(a_ignored_hold,
        accept && !byte_in.clear && (state_reg == ST_DONE || state_reg == ST_ERROR),
        $stable(pos_reg) && $stable(name_reg) && $stable(vend_reg),
        "ignored byte changed parser state")

    // A failing byte always parks the parser in error.
    `HHFP_ASSERT_NEXT(a_fail_state, accept,
        res_reg.status != STAT_FAIL || state_reg == ST_ERROR,
        "error status without error state")

endmodule
